/* rtl/keyed_pair_trip_counter_core_macros.svh */
// Assertion macros for the keyed pair trip counter.
// Used by the top level; the enclosing module supplies clk_i and rst_ni.
`ifndef KEYED_PAIR_TRIP_COUNTER_CORE_MACROS_SVH
`define KEYED_PAIR_TRIP_COUNTER_CORE_MACROS_SVH

// Same-cycle implication.
`define KPTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KPTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kptc_pkg.sv */
// Package for the keyed pair trip counter: request, status and state codes,
// and the scan status struct. No dependencies.
`timescale 1ns / 1ps

package kptc_pkg;

  localparam int MONTH_SLOTS = 12;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_RIDE     = 2'd1,
    REQ_READ     = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNKNOWN   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_MONTH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_READ,
    S_UPDATE,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic done;
    logic hit_a;
    logic hit_b;
  } scan_stat_t;

endpackage

/* rtl/kptc_id_scan.sv */
// Station id table with a pipelined linear search for two keys at once.
// Depends on kptc_pkg.
`timescale 1ns / 1ps

module kptc_id_scan #(
  parameter int MAX_STATIONS = 256,
  localparam int IW = $clog2(MAX_STATIONS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         key_a_i,
  input  logic [31:0]         key_b_i,
  input  logic [IW:0]         count_i,
  input  logic                wr_en_i,
  input  logic [IW-1:0]       wr_addr_i,
  input  logic [31:0]         wr_data_i,
  output kptc_pkg::scan_stat_t stat_o,
  output logic [IW-1:0]       idx_a_o,
  output logic [IW-1:0]       idx_b_o
);
  import kptc_pkg::*;

  logic [31:0]   id_mem [MAX_STATIONS];
  logic [31:0]   rdata_q;
  logic          active_q, pend_q, hit_a_q, hit_b_q;
  logic [IW:0]   addr_q;
  logic [IW-1:0] pend_idx_q, idx_a_q, idx_b_q;
  logic          rd_en;

  assign rd_en = active_q && (addr_q < count_i);

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rdata_q <= id_mem[addr_q[IW-1:0]];
    end
  end

  // Search control: issue one address a cycle, compare the previous read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      hit_a_q  <= 1'b0;
      hit_b_q  <= 1'b0;
      addr_q   <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      pend_q   <= 1'b0;
      hit_a_q  <= 1'b0;
      hit_b_q  <= 1'b0;
      addr_q   <= '0;
    end else if (active_q) begin
      // earliest match wins: only the first hit is kept
      if (pend_q && !hit_a_q && rdata_q == key_a_i) begin
        hit_a_q <= 1'b1;
      end
      if (pend_q && !hit_b_q && rdata_q == key_b_i) begin
        hit_b_q <= 1'b1;
      end
      pend_q <= rd_en;
      if (rd_en) begin
        addr_q <= addr_q + 1'b1;
      end
      if (stat_o.done) begin
        active_q <= 1'b0;
      end
    end
  end

  // Index capture
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pend_idx_q <= addr_q[IW-1:0];
    end
    if (active_q && pend_q && !hit_a_q && rdata_q == key_a_i) begin
      idx_a_q <= pend_idx_q;
    end
    if (active_q && pend_q && !hit_b_q && rdata_q == key_b_i) begin
      idx_b_q <= pend_idx_q;
    end
  end

  assign stat_o.done  = active_q && !pend_q && !rd_en;
  assign stat_o.hit_a = hit_a_q;
  assign stat_o.hit_b = hit_b_q;
  assign idx_a_o      = idx_a_q;
  assign idx_b_o      = idx_b_q;

endmodule

/* rtl/keyed_pair_trip_counter_core.sv */
// Channel | dir | handshake                | payload
// in      | in  | in_valid_i / in_stall_o  | req_type, first_id, second_id, is_member, month
// out     | out | out_valid_o / out_stall_i| status, first_index, count_ab/ba, member, month
//
// Register: straight to the final step. Ride or read: the one-entry-a-cycle id
// table scan over the registered stations, then a counter read and update (both
// skipped for an unknown id or a bad month), then the final step.
// After reset a clearing pass over max(MAX_STATIONS^2, 12*MAX_STATIONS) addresses
// (65536 at defaults) zeroes the counter memories; no input is taken meanwhile.
// A result held by out_stall_i holds the block in its final step; one new
// request may still be taken while a result waits.
// Top level of the keyed pair trip counter; depends on kptc_pkg, kptc_id_scan
// and keyed_pair_trip_counter_core_macros.svh.
`timescale 1ns / 1ps

module keyed_pair_trip_counter_core #(
  parameter int MAX_STATIONS = 256,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] first_id_i,
  input  logic [31:0] second_id_i,
  input  logic        is_member_i,
  input  logic [3:0]  month_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  first_index_o,
  output logic [31:0] count_ab_o,
  output logic [31:0] count_ba_o,
  output logic [31:0] member_count_o,
  output logic [31:0] month_count_o
);
  import kptc_pkg::*;
  `include "keyed_pair_trip_counter_core_macros.svh"

  localparam int IW      = $clog2(MAX_STATIONS);
  localparam int PAIR_N  = MAX_STATIONS * MAX_STATIONS;
  localparam int MONTH_N = MAX_STATIONS * MONTH_SLOTS;
  localparam int PAW     = $clog2(PAIR_N);
  localparam int MAW     = $clog2(MONTH_N);
  localparam int CLR_N   = (PAIR_N > MONTH_N) ? PAIR_N : MONTH_N;
  localparam int CLW     = $clog2(CLR_N);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t bump(input cnt_t v);
    return (&v) ? v : cnt_t'(v + 1'b1);
  endfunction

  state_e     state_q, state_d;
  logic [CLW-1:0] clr_q;
  logic [IW:0]    cnt_q;

  req_e        kind_q;
  logic [31:0] a_id_q, b_id_q;
  logic        member_q;
  logic [3:0]  month_q;

  status_e     res_status_q;
  logic [7:0]  res_index_q;
  logic [31:0] res_ab_q, res_ba_q, res_mem_q, res_mon_q;

  logic        out_valid_q;
  status_e     out_status_q;
  logic [7:0]  out_index_q;
  logic [31:0] out_ab_q, out_ba_q, out_mem_q, out_mon_q;

  scan_stat_t    scan_stat;
  logic [IW-1:0] idx_a, idx_b;

  logic accept, scan_start, tbl_wr, out_free, out_load, month_ok, is_ride;
  logic [PAW-1:0] addr_ab, addr_ba;
  logic [IW-1:0]  addr_mem;
  logic [MAW-1:0] addr_mon;
  cnt_t pab_q, pba_q, pmem_q, pmon_q;
  cnt_t nab, nmem, nmon;
  req_e in_kind;

  assign in_kind  = req_e'(req_type_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign month_ok = (month_q >= 4'd1) && (month_q <= 4'(MONTH_SLOTS));
  assign is_ride  = (kind_q == REQ_RIDE);

  // Id table and search
  kptc_id_scan #(.MAX_STATIONS(MAX_STATIONS)) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_start),
    .key_a_i   (a_id_q),
    .key_b_i   (b_id_q),
    .count_i   (cnt_q),
    .wr_en_i   (tbl_wr),
    .wr_addr_i (cnt_q[IW-1:0]),
    .wr_data_i (first_id_i),
    .stat_o    (scan_stat),
    .idx_a_o   (idx_a),
    .idx_b_o   (idx_b)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == CLW'(CLR_N - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            REQ_REGISTER:       state_d = S_FINISH;
            REQ_RIDE, REQ_READ: state_d = S_SCAN;
            default:            state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_d = (scan_stat.hit_a && scan_stat.hit_b && month_ok) ? S_READ : S_FINISH;
        end
      end
      S_READ:   state_d = S_UPDATE;
      S_UPDATE: state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    scan_start = accept && (in_kind inside {REQ_RIDE, REQ_READ});
    tbl_wr     = accept && (in_kind == REQ_REGISTER) && (cnt_q < (IW+1)'(MAX_STATIONS));
    out_load   = (state_q == S_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (tbl_wr) cnt_q <= cnt_q + 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Counter memory addresses
  assign addr_ab  = PAW'(idx_a * MAX_STATIONS + idx_b);
  assign addr_ba  = PAW'(idx_b * MAX_STATIONS + idx_a);
  assign addr_mem = idx_a;
  assign addr_mon = MAW'(idx_a * MONTH_SLOTS + (month_q - 4'd1));

  assign nab  = bump(pab_q);
  assign nmem = bump(pmem_q);
  assign nmon = bump(pmon_q);

  // Pair count memory: clear pass, two reads, one write back
  cnt_t pair_mem [PAIR_N];
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      if (clr_q < CLW'(PAIR_N - 1) || clr_q == CLW'(PAIR_N - 1)) begin
        pair_mem[PAW'(clr_q)] <= '0;
      end
    end else if (state_q == S_UPDATE && is_ride) begin
      pair_mem[addr_ab] <= nab;
    end
    if (state_q == S_READ) begin
      pab_q <= pair_mem[addr_ab];
      pba_q <= pair_mem[addr_ba];
    end
  end

  // Member count memory
  cnt_t member_mem [MAX_STATIONS];
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      if (clr_q < CLW'(MAX_STATIONS)) member_mem[IW'(clr_q)] <= '0;
    end else if (state_q == S_UPDATE && is_ride && member_q) begin
      member_mem[addr_mem] <= nmem;
    end
    if (state_q == S_READ) pmem_q <= member_mem[addr_mem];
  end

  // Month count memory
  cnt_t month_mem [MONTH_N];
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      if (clr_q < CLW'(MONTH_N - 1) || clr_q == CLW'(MONTH_N - 1)) begin
        month_mem[MAW'(clr_q)] <= '0;
      end
    end else if (state_q == S_UPDATE && is_ride) begin
      month_mem[addr_mon] <= nmon;
    end
    if (state_q == S_READ) pmon_q <= month_mem[addr_mon];
  end

  // Request capture and result staging
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= in_kind;
      a_id_q   <= first_id_i;
      b_id_q   <= second_id_i;
      member_q <= is_member_i;
      month_q  <= month_i;
      res_ab_q  <= '0;
      res_ba_q  <= '0;
      res_mem_q <= '0;
      res_mon_q <= '0;
      if (cnt_q < (IW+1)'(MAX_STATIONS)) begin
        res_status_q <= STAT_OK;
        res_index_q  <= 8'(cnt_q);
      end else begin
        res_status_q <= STAT_FULL;
        res_index_q  <= '0;
      end
    end
    if (state_q == S_SCAN && scan_stat.done) begin
      // error results carry a zero index
      res_index_q <= '0;
      if (!(scan_stat.hit_a && scan_stat.hit_b)) begin
        res_status_q <= STAT_UNKNOWN;
      end else if (!month_ok) begin
        res_status_q <= STAT_BAD_MONTH;
      end
    end
    if (state_q == S_UPDATE) begin
      res_status_q <= STAT_OK;
      res_index_q  <= 8'(idx_a);
      res_ab_q     <= 32'(is_ride ? nab : pab_q);
      res_ba_q     <= (idx_a == idx_b) ? 32'(is_ride ? nab : pab_q) : 32'(pba_q);
      res_mem_q    <= 32'((is_ride && member_q) ? nmem : pmem_q);
      res_mon_q    <= 32'(is_ride ? nmon : pmon_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_index_q;
      out_ab_q     <= res_ab_q;
      out_ba_q     <= res_ba_q;
      out_mem_q    <= res_mem_q;
      out_mon_q    <= res_mon_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign first_index_o  = out_index_q;
  assign count_ab_o     = out_ab_q;
  assign count_ba_o     = out_ba_q;
  assign member_count_o = out_mem_q;
  assign month_count_o  = out_mon_q;

  // Checks
  `KPTC_ASSERT_NOW(a_scan_done_in_scan, scan_stat.done, state_q == S_SCAN, "scan done outside scan")
  `KPTC_ASSERT_NOW(a_update_after_read, state_q == S_UPDATE, $past(state_q) == S_READ, "update without read")
  `KPTC_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= (IW+1)'(MAX_STATIONS), "station count overflow")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for keyed_pair_trip_counter_core: station registry,
// ride counters and reads checked against an in-bench predictor.
// Depends on kptc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import kptc_pkg::*;

  localparam int STATIONS  = 256;
  localparam int N_RANDOM  = 1150;

  typedef struct {
    req_e        kind;
    logic [31:0] id_a;
    logic [31:0] id_b;
    logic        member;
    logic [3:0]  mon;
    int          gap_pct;
    int          stall_pct;
    bit          drain;
  } trip_req_t;

  typedef struct {
    status_e     st;
    logic [7:0]  idx;
    logic [31:0] ab;
    logic [31:0] ba;
    logic [31:0] mem_cnt;
    logic [31:0] mon_cnt;
  } trip_res_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  req_type_i;
  logic [31:0] first_id_i, second_id_i;
  logic        is_member_i;
  logic [3:0]  month_i;
  logic        out_valid_o, out_stall_i;
  logic [1:0]  status_o;
  logic [7:0]  first_index_o;
  logic [31:0] count_ab_o, count_ba_o, member_count_o, month_count_o;

  keyed_pair_trip_counter_core dut (.*);

  // Predictor state
  logic [31:0] station_ids [STATIONS];
  int          n_stations;
  logic [31:0] pair_tab    [STATIONS*STATIONS];
  logic [31:0] member_tab  [STATIONS];
  logic [31:0] month_tab   [STATIONS*MONTH_SLOTS];

  trip_req_t   pending_reqs[$];
  trip_res_t   expected_res[$];
  trip_req_t   cur_req;
  int          stall_pct;
  int          errors;
  logic [31:0] gen_ids[$];

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  function automatic int find_station(logic [31:0] id);
    for (int i = 0; i < n_stations; i++)
      if (station_ids[i] == id) return i;
    return -1;
  endfunction

  // Apply one request to the predicted state; returns 0 when no result follows
  function automatic bit apply_trip(trip_req_t r, output trip_res_t res);
    int a, b, m;
    res = '{STAT_OK, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    if (r.kind == REQ_NONE) return 0;
    if (r.kind == REQ_REGISTER) begin
      if (n_stations >= STATIONS) begin
        res.st = STAT_FULL;
      end else begin
        station_ids[n_stations] = r.id_a;
        res.idx = n_stations[7:0];
        n_stations++;
      end
      return 1;
    end
    a = find_station(r.id_a);
    b = find_station(r.id_b);
    if (a < 0 || b < 0) begin
      res.st = STAT_UNKNOWN;
      return 1;
    end
    if (r.mon < 1 || r.mon > MONTH_SLOTS) begin
      res.st = STAT_BAD_MONTH;
      return 1;
    end
    m = r.mon - 1;
    if (r.kind == REQ_RIDE) begin
      pair_tab[a*STATIONS+b] = bump(pair_tab[a*STATIONS+b]);
      if (r.member) member_tab[a] = bump(member_tab[a]);
      month_tab[a*MONTH_SLOTS+m] = bump(month_tab[a*MONTH_SLOTS+m]);
    end
    res.idx     = a[7:0];
    res.ab      = pair_tab[a*STATIONS+b];
    res.ba      = pair_tab[b*STATIONS+a];
    res.mem_cnt = member_tab[a];
    res.mon_cnt = month_tab[a*MONTH_SLOTS+m];
    return 1;
  endfunction

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] got_v);
    $display("mismatch %s: expected %0h got %0h at %0t", field, exp_v, got_v, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] pick_id();
    if (gen_ids.size() == 0 || $urandom_range(99) < 12) return $urandom();
    if ($urandom_range(1) == 0) return gen_ids[$urandom_range(gen_ids.size() < 8 ?
                                               gen_ids.size() - 1 : 7)];
    return gen_ids[$urandom_range(gen_ids.size() - 1)];
  endfunction

  task automatic push_req(req_e k, logic [31:0] a, logic [31:0] b, logic mb,
                          logic [3:0] mo, int gp, int sp, bit dr);
    trip_req_t r;
    r = '{k, a, b, mb, mo, gp, sp, dr};
    if (k == REQ_REGISTER && gen_ids.size() < STATIONS) gen_ids.push_back(a);
    pending_reqs.push_back(r);
  endtask

  // Clock
  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Driver: one transfer per accepted item, prediction at acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    trip_res_t res;
    bit fire;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      req_type_i  <= REQ_NONE;
      first_id_i  <= '0;
      second_id_i <= '0;
      is_member_i <= 1'b0;
      month_i     <= '0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire && apply_trip(cur_req, res)) expected_res.push_back(res);
      if (!in_valid_i || fire) begin
        if (pending_reqs.size() > 0 &&
            !(pending_reqs[0].drain && (expected_res.size() > 0 || out_valid_o || fire)) &&
            $urandom_range(99) >= pending_reqs[0].gap_pct) begin
          cur_req = pending_reqs.pop_front();
          stall_pct   = cur_req.stall_pct;
          in_valid_i  <= 1'b1;
          req_type_i  <= cur_req.kind;
          first_id_i  <= cur_req.id_a;
          second_id_i <= cur_req.id_b;
          is_member_i <= cur_req.member;
          month_i     <= cur_req.mon;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    trip_res_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_res.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if (status_o !== e.st)            report("status", e.st, status_o);
          if (first_index_o !== e.idx)      report("first_index", e.idx, first_index_o);
          if (count_ab_o !== e.ab)          report("count_ab", e.ab, count_ab_o);
          if (count_ba_o !== e.ba)          report("count_ba", e.ba, count_ba_o);
          if (member_count_o !== e.mem_cnt) report("member_count", e.mem_cnt, member_count_o);
          if (month_count_o !== e.mon_cnt)  report("month_count", e.mon_cnt, month_count_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Stimulus and end of run
  initial begin
    int gp, sp, r;
    req_e k;
    errors = 0;
    n_stations = 0;
    stall_pct = 0;
    foreach (pair_tab[i]) pair_tab[i] = '0;
    foreach (member_tab[i]) member_tab[i] = '0;
    foreach (month_tab[i]) month_tab[i] = '0;

    // Directed: empty table, id extremes, duplicates, months, same station
    push_req(REQ_RIDE, 32'h0, 32'h0, 1, 4'd1, 0, 0, 0);
    push_req(REQ_READ, 32'h0, 32'h0, 0, 4'd1, 0, 0, 0);
    push_req(REQ_REGISTER, 32'h0, 32'h0, 0, 4'd0, 0, 0, 0);
    push_req(REQ_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 4'd15, 0, 0, 0);
    push_req(REQ_REGISTER, 32'h0, 32'h1234_5678, 0, 4'd3, 0, 0, 0);
    push_req(REQ_REGISTER, 32'h5A5A_A5A5, 32'h0, 0, 4'd0, 0, 0, 0);
    push_req(REQ_RIDE, 32'h0, 32'hFFFF_FFFF, 1, 4'd1, 0, 0, 0);
    push_req(REQ_RIDE, 32'hFFFF_FFFF, 32'h0, 0, 4'd12, 0, 0, 0);
    push_req(REQ_RIDE, 32'h0, 32'h0, 1, 4'd7, 0, 0, 0);
    push_req(REQ_RIDE, 32'h0, 32'hFFFF_FFFF, 1, 4'd1, 0, 0, 0);
    push_req(REQ_READ, 32'h0, 32'hFFFF_FFFF, 0, 4'd1, 0, 0, 0);
    push_req(REQ_READ, 32'hFFFF_FFFF, 32'h0, 1, 4'd12, 0, 0, 0);
    push_req(REQ_READ, 32'h0, 32'h0, 0, 4'd7, 0, 0, 0);
    push_req(REQ_READ, 32'h0, 32'h5A5A_A5A5, 0, 4'd0, 0, 0, 0);
    push_req(REQ_RIDE, 32'h0, 32'h5A5A_A5A5, 1, 4'd13, 0, 0, 0);
    push_req(REQ_RIDE, 32'h5A5A_A5A5, 32'h0, 1, 4'd15, 0, 0, 0);
    push_req(REQ_RIDE, 32'h0, 32'h7777_7777, 1, 4'd2, 0, 0, 0);
    push_req(REQ_READ, 32'h1111_1111, 32'h0, 0, 4'd0, 0, 0, 0);
    push_req(REQ_NONE, 32'h0, 32'hFFFF_FFFF, 1, 4'd5, 0, 0, 0);
    push_req(REQ_RIDE, 32'h5A5A_A5A5, 32'h5A5A_A5A5, 0, 4'd6, 0, 0, 0);

    // Random: four phases of input gaps and output stalls (the first with neither), table fills partway through
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i * 4 / N_RANDOM)
        0:       begin gp = 0;  sp = 0;  end
        1:       begin gp = 86; sp = 0;  end
        2:       begin gp = 0;  sp = 86; end
        default: begin gp = 38; sp = 38; end
      endcase
      r = $urandom_range(99);
      if (r < 3)                                            k = REQ_NONE;
      else if (r < (gen_ids.size() < STATIONS ? 33 : 10))  k = REQ_REGISTER;
      else if (r < 70)                                      k = REQ_RIDE;
      else                                                  k = REQ_READ;
      push_req(k,
               (k == REQ_REGISTER && gen_ids.size() > 0 && $urandom_range(99) < 15) ?
                 gen_ids[$urandom_range(gen_ids.size() - 1)] :
                 (k == REQ_REGISTER ? $urandom() : pick_id()),
               pick_id(), $urandom_range(1),
               ($urandom_range(99) < 85) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(15)),
               gp, sp, i == 400);
    end

    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_reqs.size() > 0 || in_valid_i || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #(12.0 * 3_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/kptc_pkg.sv
rtl/kptc_id_scan.sv
rtl/keyed_pair_trip_counter_core.sv
tb/sv/tb.sv
